FILE: src/knn_pkg.sv
package knn_pkg;

   localparam int FeatW     = 11;
   localparam int SqW       = 2 * FeatW;
   localparam int PairW     = SqW + 1;
   localparam int DistW     = 25;
   localparam int LabelW    = 4;
   localparam int RecIdW    = 16;
   localparam int CountW    = 2;
   localparam int MaxFeat   = 8;
   localparam int NumPairs  = MaxFeat / 2;
   localparam int NumQuery  = 8;
   localparam int OutSlots  = 3;
   localparam int CsrDataW  = 32;
   localparam int CsrIdxW   = $clog2(NumQuery);
   localparam int CsrAddrW  = CsrIdxW + 2;

   localparam int NUM_FEATURES_DEF   = 8;
   localparam int NUM_NEIGHBOURS_DEF = 3;
   localparam int ID_WIDTH_DEF       = 16;

   // side data that travels with a record down the distance pipeline
   typedef struct packed {
      logic [LabelW-1:0] label;
      logic [RecIdW-1:0] id;
      logic              last;
   } meta_type;

   // one reported neighbour; fields are zero when the slot is empty
   typedef struct packed {
      logic              valid;
      logic [DistW-1:0]  distance;
      logic [RecIdW-1:0] id;
      logic [LabelW-1:0] label;
   } nbr_type;

endpackage

FILE: src/knn_lane.sv
module knn_lane
   import knn_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [FeatW-1:0] score,
   input  logic [FeatW-1:0] query,
   output logic [SqW-1:0]   sq_ff
);

   logic [FeatW-1:0] diff;
   logic [SqW-1:0]   sq_in;

   always_comb begin
      diff  = (score > query) ? (score - query) : (query - score);
      sq_in = SqW'(diff) * SqW'(diff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

endmodule

FILE: src/knn_sum.sv
module knn_sum
   import knn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SqW-1:0]   in_sq [MaxFeat],
   input  meta_type         in_meta,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DistW-1:0] out_dist,
   output meta_type         out_meta
);

   logic             pa_valid_ff;
   logic [PairW-1:0] pa_sum_ff [NumPairs];
   meta_type         pa_meta_ff;
   logic             pb_valid_ff;
   logic [DistW-1:0] pb_dist_ff;
   meta_type         pb_meta_ff;
   logic             pa_ready;
   logic             pb_ready;
   logic [DistW-1:0] pb_dist_in;

   assign pb_ready = !pb_valid_ff || out_ready;
   assign pa_ready = !pa_valid_ff || pb_ready;
   assign in_ready = pa_ready;

   always_comb begin
      pb_dist_in = '0;
      for (int p = 0; p < NumPairs; p++) begin
         pb_dist_in = pb_dist_in + DistW'(pa_sum_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
         pb_valid_ff <= 1'b0;
      end else begin
         if (pa_ready) begin
            pa_valid_ff <= in_valid;
         end
         if (pb_ready) begin
            pb_valid_ff <= pa_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pa_ready && in_valid) begin
         for (int p = 0; p < NumPairs; p++) begin
            pa_sum_ff[p] <= PairW'(in_sq[2*p]) + PairW'(in_sq[2*p+1]);
         end
         pa_meta_ff <= in_meta;
      end
      if (pb_ready && pa_valid_ff) begin
         pb_dist_ff <= pb_dist_in;
         pb_meta_ff <= pa_meta_ff;
      end
   end

   assign out_valid = pb_valid_ff;
   assign out_dist  = pb_dist_ff;
   assign out_meta  = pb_meta_ff;

endmodule

FILE: src/knn_slots.sv
module knn_slots
   import knn_pkg::*;
#(
   parameter int NUM_NEIGHBOURS = NUM_NEIGHBOURS_DEF,
   parameter int ID_WIDTH       = ID_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DistW-1:0] in_dist,
   input  meta_type         in_meta,
   output logic             out_valid,
   input  logic             out_ready,
   output nbr_type          out_nbr [OutSlots]
);

   logic                valid_ff [NUM_NEIGHBOURS];
   logic [DistW-1:0]    dist_ff  [NUM_NEIGHBOURS];
   logic [ID_WIDTH-1:0] id_ff    [NUM_NEIGHBOURS];
   logic [LabelW-1:0]   label_ff [NUM_NEIGHBOURS];

   logic                valid_in [NUM_NEIGHBOURS];
   logic [DistW-1:0]    dist_in  [NUM_NEIGHBOURS];
   logic [ID_WIDTH-1:0] id_in    [NUM_NEIGHBOURS];
   logic [LabelW-1:0]   label_in [NUM_NEIGHBOURS];
   logic                nearer   [NUM_NEIGHBOURS];

   logic                snap_valid_ff;
   nbr_type             snap_ff  [OutSlots];
   nbr_type             snap_in  [OutSlots];
   logic                snap_ready;
   logic                take;
   logic [31:0]         rec_id_ext;
   logic [ID_WIDTH-1:0] rec_id;

   assign snap_ready = !snap_valid_ff || out_ready;
   assign in_ready   = !in_meta.last || snap_ready;
   assign take       = in_valid && in_ready;
   assign rec_id_ext = 32'(in_meta.id);
   assign rec_id     = rec_id_ext[ID_WIDTH-1:0];

   // slots are sorted and filled from slot 0, so nearer[] is monotonic and its
   // first set bit is the insert position
   always_comb begin
      for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
         nearer[k] = !valid_ff[k] || (in_dist < dist_ff[k]);
      end
      for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
         valid_in[k] = valid_ff[k];
         dist_in[k]  = dist_ff[k];
         id_in[k]    = id_ff[k];
         label_in[k] = label_ff[k];
         if (nearer[k]) begin
            if (k == 0) begin
               valid_in[k] = 1'b1;
               dist_in[k]  = in_dist;
               id_in[k]    = rec_id;
               label_in[k] = in_meta.label;
            end else if (!nearer[(k == 0) ? 0 : k - 1]) begin
               valid_in[k] = 1'b1;
               dist_in[k]  = in_dist;
               id_in[k]    = rec_id;
               label_in[k] = in_meta.label;
            end else begin
               valid_in[k] = valid_ff[(k == 0) ? 0 : k - 1];
               dist_in[k]  = dist_ff[(k == 0) ? 0 : k - 1];
               id_in[k]    = id_ff[(k == 0) ? 0 : k - 1];
               label_in[k] = label_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   for (genvar s = 0; s < OutSlots; s++) begin : g_snap
      if (s < NUM_NEIGHBOURS) begin : g_used
         logic [31:0] id_ext;
         assign id_ext = 32'(id_in[s]);
         always_comb begin
            snap_in[s].valid    = valid_in[s];
            snap_in[s].distance = valid_in[s] ? dist_in[s] : '0;
            snap_in[s].id       = valid_in[s] ? id_ext[RecIdW-1:0] : '0;
            snap_in[s].label    = valid_in[s] ? label_in[s] : '0;
         end
      end else begin : g_none
         assign snap_in[s] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
            valid_ff[k] <= 1'b0;
         end
         snap_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
               valid_ff[k] <= in_meta.last ? 1'b0 : valid_in[k];
            end
         end
         if (take && in_meta.last) begin
            snap_valid_ff <= 1'b1;
         end else if (out_ready) begin
            snap_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int k = 0; k < NUM_NEIGHBOURS; k++) begin
            dist_ff[k]  <= dist_in[k];
            id_ff[k]    <= id_in[k];
            label_ff[k] <= label_in[k];
         end
      end
      if (take && in_meta.last) begin
         snap_ff <= snap_in;
      end
   end

   assign out_valid = snap_valid_ff;
   assign out_nbr   = snap_ff;

endmodule

FILE: src/knn_vote.sv
module knn_vote
   import knn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  nbr_type           in_nbr [OutSlots],
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nbr_type           rsp_nbr [OutSlots],
   output logic [CountW-1:0] rsp_count,
   output logic [LabelW-1:0] rsp_vote
);

   logic              valid_ff;
   nbr_type           nbr_ff [OutSlots];
   logic [CountW-1:0] count_ff;
   logic [LabelW-1:0] vote_ff;
   logic [CountW-1:0] count_in;
   logic [LabelW-1:0] vote_in;
   logic              m01, m02, m12;

   assign in_ready = !valid_ff || !rsp_stall;

   always_comb begin
      count_in = CountW'(in_nbr[0].valid) + CountW'(in_nbr[1].valid)
               + CountW'(in_nbr[2].valid);
      m01 = in_nbr[0].valid && in_nbr[1].valid && (in_nbr[0].label == in_nbr[1].label);
      m02 = in_nbr[0].valid && in_nbr[2].valid && (in_nbr[0].label == in_nbr[2].label);
      m12 = in_nbr[1].valid && in_nbr[2].valid && (in_nbr[1].label == in_nbr[2].label);
      // empty slots carry label 0, but every match term requires both slots to be valid
      priority if (m01 || m02) begin
         vote_in = in_nbr[0].label;
      end else if (m12) begin
         vote_in = in_nbr[1].label;
      end else begin
         vote_in = in_nbr[0].label;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         nbr_ff   <= in_nbr;
         count_ff <= count_in;
         vote_ff  <= vote_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_nbr   = nbr_ff;
   assign rsp_count = count_ff;
   assign rsp_vote  = vote_ff;

endmodule

FILE: src/knn_top3_majority_vote.sv
// channel   direction  handshake             carries
// req_*     in         req_valid/req_stall   one reference record per transfer
// rsp_*     out        rsp_valid/rsp_stall   three neighbours, count and vote per last record
// csr_*     in         APB psel/penable      query features 0..7 at byte address 4*i
//
// One record per cycle while req_stall is low; the slot list updates once per record, which
// sets the rate. rsp_valid rises once the last record has passed the lane square register,
// the two adder-tree stages, the slot update and the vote register.
// Synchronous reset empties all slots and pipeline stages and clears the query.
// While rsp_stall holds a result the slot stage still keeps one more; the last record
// after that waits at the slot list, and req_stall rises once the two stages behind it fill.
module knn_top3_majority_vote
   import knn_pkg::*;
#(
   parameter int NUM_FEATURES   = NUM_FEATURES_DEF,
   parameter int NUM_NEIGHBOURS = NUM_NEIGHBOURS_DEF,
   parameter int ID_WIDTH       = ID_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FeatW-1:0]    req_score_0,
   input  logic [FeatW-1:0]    req_score_1,
   input  logic [FeatW-1:0]    req_score_2,
   input  logic [FeatW-1:0]    req_score_3,
   input  logic [FeatW-1:0]    req_score_4,
   input  logic [FeatW-1:0]    req_score_5,
   input  logic [FeatW-1:0]    req_score_6,
   input  logic [FeatW-1:0]    req_score_7,
   input  logic [LabelW-1:0]   req_type_label,
   input  logic [RecIdW-1:0]   req_record_id,
   input  logic                req_last_record,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RecIdW-1:0]   rsp_first_id,
   output logic [DistW-1:0]    rsp_first_distance,
   output logic [LabelW-1:0]   rsp_first_label,
   output logic [RecIdW-1:0]   rsp_second_id,
   output logic [DistW-1:0]    rsp_second_distance,
   output logic [LabelW-1:0]   rsp_second_label,
   output logic [RecIdW-1:0]   rsp_third_id,
   output logic [DistW-1:0]    rsp_third_distance,
   output logic [LabelW-1:0]   rsp_third_label,
   output logic [CountW-1:0]   rsp_filled_count,
   output logic [LabelW-1:0]   rsp_predicted_label,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   logic [FeatW-1:0]   query_ff [NumQuery];
   logic [CsrIdxW-1:0] csr_idx;
   logic               csr_wr;

   logic [FeatW-1:0]   score [MaxFeat];
   logic [SqW-1:0]     sq    [MaxFeat];
   logic               s1_valid_ff;
   meta_type           s1_meta_ff;
   logic               s1_ready;
   logic               s1_load;

   logic               sum_ready;
   logic               sum_valid;
   logic [DistW-1:0]   sum_dist;
   meta_type           sum_meta;
   logic               slot_ready;
   logic               snap_valid;
   logic               vote_ready;
   nbr_type            snap_nbr [OutSlots];
   nbr_type            rsp_nbr  [OutSlots];

   // configuration
   assign csr_idx    = csr_paddr[CsrAddrW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = CsrDataW'(query_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NumQuery; q++) begin
            query_ff[q] <= '0;
         end
      end else if (csr_wr) begin
         query_ff[csr_idx] <= csr_pwdata[FeatW-1:0];
      end
   end

   // feature lanes
   assign score[0] = req_score_0;
   assign score[1] = req_score_1;
   assign score[2] = req_score_2;
   assign score[3] = req_score_3;
   assign score[4] = req_score_4;
   assign score[5] = req_score_5;
   assign score[6] = req_score_6;
   assign score[7] = req_score_7;

   assign s1_ready  = !s1_valid_ff || sum_ready;
   assign s1_load   = req_valid && s1_ready;
   assign req_stall = !s1_ready;

   for (genvar f = 0; f < MaxFeat; f++) begin : g_lane
      if (f < NUM_FEATURES) begin : g_on
         knn_lane u_lane (
            .clock (clock),
            .en    (s1_load),
            .score (score[f]),
            .query (query_ff[f]),
            .sq_ff (sq[f])
         );
      end else begin : g_off
         assign sq[f] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_meta_ff.label <= req_type_label;
         s1_meta_ff.id    <= req_record_id;
         s1_meta_ff.last  <= req_last_record;
      end
   end

   knn_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (sum_ready),
      .in_sq     (sq),
      .in_meta   (s1_meta_ff),
      .out_valid (sum_valid),
      .out_ready (slot_ready),
      .out_dist  (sum_dist),
      .out_meta  (sum_meta)
   );

   knn_slots #(
      .NUM_NEIGHBOURS (NUM_NEIGHBOURS),
      .ID_WIDTH       (ID_WIDTH)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (slot_ready),
      .in_dist   (sum_dist),
      .in_meta   (sum_meta),
      .out_valid (snap_valid),
      .out_ready (vote_ready),
      .out_nbr   (snap_nbr)
   );

   knn_vote u_vote (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (snap_valid),
      .in_ready  (vote_ready),
      .in_nbr    (snap_nbr),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_nbr   (rsp_nbr),
      .rsp_count (rsp_filled_count),
      .rsp_vote  (rsp_predicted_label)
   );

   assign rsp_first_id        = rsp_nbr[0].id;
   assign rsp_first_distance  = rsp_nbr[0].distance;
   assign rsp_first_label     = rsp_nbr[0].label;
   assign rsp_second_id       = rsp_nbr[1].id;
   assign rsp_second_distance = rsp_nbr[1].distance;
   assign rsp_second_label    = rsp_nbr[1].label;
   assign rsp_third_id        = rsp_nbr[2].id;
   assign rsp_third_distance  = rsp_nbr[2].distance;
   assign rsp_third_label     = rsp_nbr[2].label;

endmodule

FILE: src/knn_chk.sv
module knn_chk
   import knn_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [RecIdW-1:0]   rsp_first_id,
   input logic [DistW-1:0]    rsp_first_distance,
   input logic [LabelW-1:0]   rsp_first_label,
   input logic [RecIdW-1:0]   rsp_second_id,
   input logic [DistW-1:0]    rsp_second_distance,
   input logic [LabelW-1:0]   rsp_second_label,
   input logic [CountW-1:0]   rsp_filled_count,
   input logic [LabelW-1:0]   rsp_predicted_label
);

   // held result keeps its contents across a stall
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_id)
         && $stable(rsp_first_distance) && $stable(rsp_predicted_label))
      else $error("result changed while stalled");

   // neighbours are reported nearest first
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filled_count >= 2'd2 |-> rsp_first_distance <= rsp_second_distance)
      else $error("neighbours out of order");

   // an empty set reports zero fields and vote
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filled_count == 2'd0 |->
         rsp_first_id == '0 && rsp_first_distance == '0 && rsp_predicted_label == '0)
      else $error("empty result not zero");

   // a single neighbour leaves the second slot zero
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filled_count == 2'd1 |->
         rsp_second_id == '0 && rsp_second_distance == '0 && rsp_second_label == '0
         && rsp_predicted_label == rsp_first_label)
      else $error("single neighbour result wrong");

   // two agreeing nearest labels decide the vote
   a_vote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_filled_count >= 2'd2 && rsp_first_label == rsp_second_label
         |-> rsp_predicted_label == rsp_first_label)
      else $error("vote ignores matching nearest labels");

endmodule

bind knn_top3_majority_vote knn_chk u_knn_chk (.*);

FILE: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import knn_pkg::*;

   localparam int NumSlots  = 3;
   localparam int ShowLimit = 10;

   typedef struct packed {
      logic [MaxFeat-1:0][FeatW-1:0] score;
      logic [LabelW-1:0]             label;
      logic [RecIdW-1:0]             id;
      logic                          last;
   } record_type;

   typedef struct packed {
      logic [OutSlots-1:0][RecIdW-1:0] id;
      logic [OutSlots-1:0][DistW-1:0]  distance;
      logic [OutSlots-1:0][LabelW-1:0] label;
      logic [CountW-1:0]               count;
      logic [LabelW-1:0]               vote;
   } vote_type;

   // a directed row may carry a hand-written result that replaces the prediction
   typedef struct packed {
      logic     fixed;
      vote_type res;
   } tag_type;

   typedef struct {
      record_type rec;
      tag_type    tag;
   } dir_row_type;

   typedef enum {
      QrySpread, QryMax, QryZeroDirty, QryAllOnes, QryFull, QryCorners
   } qsetting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic [MaxFeat-1:0][FeatW-1:0] req_score       = '0;
   logic [LabelW-1:0]             req_type_label  = '0;
   logic [RecIdW-1:0]             req_record_id   = '0;
   logic                          req_last_record = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [RecIdW-1:0]             rsp_first_id, rsp_second_id, rsp_third_id;
   logic [DistW-1:0]              rsp_first_distance, rsp_second_distance, rsp_third_distance;
   logic [LabelW-1:0]             rsp_first_label, rsp_second_label, rsp_third_label;
   logic [CountW-1:0]             rsp_filled_count;
   logic [LabelW-1:0]             rsp_predicted_label;

   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0]           csr_paddr   = '0;
   logic [CsrDataW-1:0]           csr_pwdata  = '0;
   logic [CsrDataW-1:0]           csr_prdata;
   logic                          csr_pready;

   // predictor state
   logic [FeatW-1:0]  query_model [NumQuery];
   logic [DistW-1:0]  nbr_dist    [NumSlots];
   logic [RecIdW-1:0] nbr_id      [NumSlots];
   logic [LabelW-1:0] nbr_label   [NumSlots];
   logic              nbr_full    [NumSlots];

   vote_type pending_votes [$];
   tag_type  fixed_tags    [$];

   int err_count  = 0;
   bit calm       = 1'b0;
   bit req_up     = 1'b0;
   int stall_left = 0;
   int stall_pick;

   record_type mon_rec;
   vote_type   mon_pred, mon_act, mon_exp;
   tag_type    mon_tag;
   bit         mon_emit;

   knn_top3_majority_vote u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_score_0         (req_score[0]),
      .req_score_1         (req_score[1]),
      .req_score_2         (req_score[2]),
      .req_score_3         (req_score[3]),
      .req_score_4         (req_score[4]),
      .req_score_5         (req_score[5]),
      .req_score_6         (req_score[6]),
      .req_score_7         (req_score[7]),
      .req_type_label      (req_type_label),
      .req_record_id       (req_record_id),
      .req_last_record     (req_last_record),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_first_id        (rsp_first_id),
      .rsp_first_distance  (rsp_first_distance),
      .rsp_first_label     (rsp_first_label),
      .rsp_second_id       (rsp_second_id),
      .rsp_second_distance (rsp_second_distance),
      .rsp_second_label    (rsp_second_label),
      .rsp_third_id        (rsp_third_id),
      .rsp_third_distance  (rsp_third_distance),
      .rsp_third_label     (rsp_third_label),
      .rsp_filled_count    (rsp_filled_count),
      .rsp_predicted_label (rsp_predicted_label),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      err_count++;
      if (err_count <= ShowLimit)
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
   endtask

   task automatic check_field(input string what, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v)
         note_mismatch(what, exp_v, act_v);
   endtask

   task automatic clear_neighbours();
      int k;
      for (k = 0; k < NumSlots; k++) begin
         nbr_dist[k]  = '1;
         nbr_id[k]    = '0;
         nbr_label[k] = '0;
         nbr_full[k]  = 1'b0;
      end
   endtask

   // squared distance, sorted insert; on a last record also the vote and a clear
   task automatic rank_record(input record_type r, output bit emit, output vote_type v);
      logic [DistW-1:0] d;
      logic [FeatW-1:0] diff;
      int               pos, k;
      bit               m01, m02, m12;
      d = '0;
      for (k = 0; k < MaxFeat; k++) begin
         diff = (r.score[k] > query_model[k]) ? r.score[k] - query_model[k]
                                              : query_model[k] - r.score[k];
         d = d + DistW'(diff) * DistW'(diff);
      end
      pos = NumSlots;
      for (k = NumSlots - 1; k >= 0; k--)
         if (!nbr_full[k] || d < nbr_dist[k]) pos = k;
      if (pos < NumSlots) begin
         for (k = NumSlots - 1; k > pos; k--) begin
            nbr_dist[k]  = nbr_dist[k-1];
            nbr_id[k]    = nbr_id[k-1];
            nbr_label[k] = nbr_label[k-1];
            nbr_full[k]  = nbr_full[k-1];
         end
         nbr_dist[pos]  = d;
         nbr_id[pos]    = r.id;
         nbr_label[pos] = r.label;
         nbr_full[pos]  = 1'b1;
      end
      emit = r.last;
      v = '0;
      if (emit) begin
         for (k = 0; k < OutSlots; k++) begin
            if (k < NumSlots && nbr_full[k]) begin
               v.id[k]       = nbr_id[k];
               v.distance[k] = nbr_dist[k];
               v.label[k]    = nbr_label[k];
               v.count       = v.count + 1'b1;
            end
         end
         // empty slots never take part in a match
         m01 = nbr_full[0] && nbr_full[1] && nbr_label[0] == nbr_label[1];
         m02 = nbr_full[0] && nbr_full[2] && nbr_label[0] == nbr_label[2];
         m12 = nbr_full[1] && nbr_full[2] && nbr_label[1] == nbr_label[2];
         if (m01 || m02)
            v.vote = v.label[0];
         else if (m12)
            v.vote = v.label[1];
         else
            v.vote = v.label[0];
         clear_neighbours();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumQuery; k++) query_model[k] = '0;
         clear_neighbours();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            query_model[csr_paddr[CsrAddrW-1:2]] = csr_pwdata[FeatW-1:0];
         if (req_valid && !req_stall) begin
            mon_rec.score = req_score;
            mon_rec.label = req_type_label;
            mon_rec.id    = req_record_id;
            mon_rec.last  = req_last_record;
            rank_record(mon_rec, mon_emit, mon_pred);
            mon_tag = fixed_tags.pop_front();
            if (mon_emit)
               pending_votes.push_back(mon_tag.fixed ? mon_tag.res : mon_pred);
         end
         if (rsp_valid && !rsp_stall) begin
            mon_act.id       = {rsp_third_id, rsp_second_id, rsp_first_id};
            mon_act.distance = {rsp_third_distance, rsp_second_distance, rsp_first_distance};
            mon_act.label    = {rsp_third_label, rsp_second_label, rsp_first_label};
            mon_act.count    = rsp_filled_count;
            mon_act.vote     = rsp_predicted_label;
            if (pending_votes.size() == 0) begin
               note_mismatch("unexpected result", 0, 1);
            end else begin
               mon_exp = pending_votes.pop_front();
               for (int k = 0; k < OutSlots; k++) begin
                  check_field($sformatf("slot %0d id", k), mon_exp.id[k], mon_act.id[k]);
                  check_field($sformatf("slot %0d distance", k),
                              mon_exp.distance[k], mon_act.distance[k]);
                  check_field($sformatf("slot %0d label", k),
                              mon_exp.label[k], mon_act.label[k]);
               end
               check_field("filled count", mon_exp.count, mon_act.count);
               check_field("predicted label", mon_exp.vote, mon_act.vote);
            end
         end
      end
   end

   // result side back-pressure: mostly open, short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 95) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(2, 0);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(40, 5);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   function automatic record_type mk_rec(input int base, input int s0, input int label,
                                         input int id, input bit last);
      record_type r;
      int         i;
      for (i = 0; i < MaxFeat; i++) r.score[i] = FeatW'(base);
      r.score[0] = FeatW'(s0);
      r.label    = LabelW'(label);
      r.id       = RecIdW'(id);
      r.last     = last;
      return r;
   endfunction

   function automatic tag_type mk_single(input int id, input int dist_v, input int label);
      tag_type t;
      t          = '0;
      t.fixed    = 1'b1;
      t.res.id[0]       = RecIdW'(id);
      t.res.distance[0] = DistW'(dist_v);
      t.res.label[0]    = LabelW'(label);
      t.res.count       = CountW'(1);
      t.res.vote        = LabelW'(label);
      return t;
   endfunction

   // present one record and hold it until the transfer
   task automatic send_record(input record_type r, input tag_type t);
      req_valid       <= 1'b1;
      req_up           = 1'b1;
      req_score       <= r.score;
      req_type_label  <= r.label;
      req_record_id   <= r.id;
      req_last_record <= r.last;
      fixed_tags.push_back(t);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // the clock is waited on before the queue is checked, so the monitor has queued the last transfer's result
   task automatic drain_and_settle(input int extra);
      if (req_up) begin
         req_valid <= 1'b0;
         req_up     = 1'b0;
      end
      do @(posedge clock); while (pending_votes.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_access(input int idx, input logic [CsrDataW-1:0] wdata, input bit wr);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CsrAddrW'(idx << 2);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!wr)
         check_field($sformatf("query %0d readback", idx),
                     CsrDataW'(query_model[idx]), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_query(input qsetting_type setting);
      int                  i;
      logic [FeatW-1:0]    q;
      logic [CsrDataW-1:0] wdata;
      for (i = 0; i < NumQuery; i++) begin
         case (setting)
            QrySpread:    q = FeatW'($urandom_range(1600));
            QryMax:       q = FeatW'(1600);
            QryZeroDirty: q = '0;
            QryAllOnes:   q = '1;
            QryFull:      q = FeatW'($urandom_range(2047));
            default:      q = $urandom_range(1) ? FeatW'(1600) : '0;
         endcase
         wdata = CsrDataW'(q);
         // bits above the register width are junk and must be dropped
         if (setting == QryZeroDirty || setting == QryFull)
            wdata = ($urandom() & 32'hFFFF_F800) | wdata;
         csr_access(i, wdata, 1'b1);
         csr_access(i, '0, 1'b0);
      end
   endtask

   initial begin
      dir_row_type  dir_tab [$];
      qsetting_type setting;
      record_type   r, prev;
      int           s, i, j, k, t, set_len, items;
      bit           narrow;

      // extremes straight after reset, query still all zero
      dir_tab.push_back('{mk_rec(0, 0, 5, 'h1234, 1), mk_single('h1234, 0, 5)});
      dir_tab.push_back('{mk_rec(2047, 2047, 15, 'hFFFF, 1),
                          mk_single('hFFFF, 33521672, 15)});
      dir_tab.push_back('{mk_rec(1600, 1600, 0, 0, 1), mk_single(0, 20480000, 0)});
      // vote from nearest and second
      dir_tab.push_back('{mk_rec(0, 3, 2, 10, 0), '0});
      dir_tab.push_back('{mk_rec(0, 1, 2, 11, 0), '0});
      dir_tab.push_back('{mk_rec(0, 5, 7, 12, 1), '0});
      // vote from nearest and third
      dir_tab.push_back('{mk_rec(0, 1, 4, 13, 0), '0});
      dir_tab.push_back('{mk_rec(0, 2, 9, 14, 0), '0});
      dir_tab.push_back('{mk_rec(0, 3, 4, 15, 1), '0});
      // vote from second and third
      dir_tab.push_back('{mk_rec(0, 1, 1, 16, 0), '0});
      dir_tab.push_back('{mk_rec(0, 2, 6, 17, 0), '0});
      dir_tab.push_back('{mk_rec(0, 3, 6, 18, 1), '0});
      // tie keeps the earlier record, far record dropped, eviction, no majority
      dir_tab.push_back('{mk_rec(0, 4, 3, 20, 0), '0});
      dir_tab.push_back('{mk_rec(0, 4, 8, 21, 0), '0});
      dir_tab.push_back('{mk_rec(0, 2, 5, 22, 0), '0});
      dir_tab.push_back('{mk_rec(0, 9, 11, 23, 0), '0});
      dir_tab.push_back('{mk_rec(0, 3, 12, 24, 1), '0});
      // second label 0 must not match the empty third slot
      dir_tab.push_back('{mk_rec(0, 2, 0, 30, 0), '0});
      dir_tab.push_back('{mk_rec(0, 1, 5, 31, 1), '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[n]) begin
         send_record(dir_tab[n].rec, dir_tab[n].tag);
         idle_gap(pick_gap());
      end

      prev = '0;
      for (s = 0; s < setting.num(); s++) begin
         setting = qsetting_type'(s);
         calm = 1'b0;
         drain_and_settle(10);
         program_query(setting);
         calm  = (setting == QryAllOnes);
         items = 0;
         while (items < 66) begin
            set_len = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(14, 7);
            narrow  = $urandom_range(1);
            for (j = 0; j < set_len; j++) begin
               k = $urandom_range(99);
               if (k < 10) begin
                  r.score = prev.score;
               end else begin
                  for (i = 0; i < MaxFeat; i++) begin
                     if (k < 25) begin
                        t = int'(query_model[i]) + int'($urandom_range(20)) - 10;
                        if (t < 0) t = 0;
                        if (t > 2047) t = 2047;
                        r.score[i] = FeatW'(t);
                     end else if (k < 32) begin
                        r.score[i] = FeatW'($urandom_range(2047));
                     end else begin
                        r.score[i] = FeatW'($urandom_range(1600));
                     end
                  end
               end
               r.label = narrow ? LabelW'($urandom_range(2)) : LabelW'($urandom_range(15));
               r.id    = RecIdW'($urandom_range(65535));
               r.last  = (j == set_len - 1) || ($urandom_range(99) < 3);
               send_record(r, '0);
               idle_gap(pick_gap());
               prev = r;
               items++;
            end
         end
      end

      calm = 1'b0;
      drain_and_settle(20);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
